@@ src/cowbell_drum_voice_macros.svh @@
// Assertion helpers used by the checker module.
`ifndef COWBELL_DRUM_VOICE_MACROS_SVH
`define COWBELL_DRUM_VOICE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CDV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cdv_pkg.sv @@
`default_nettype none

package cdv_pkg;

  localparam int PhaseBitsDef = 32;

  localparam int CfgW    = 25;
  localparam int VelW    = 25;
  localparam int SampleW = 16;

  localparam logic [24:0] OneQ24      = 25'd16777216;
  localparam logic [24:0] TuningRst   = 25'd8388608;
  localparam logic [24:0] EnvCoeffRst = 25'd16775631;

  localparam int F1Base = 400;
  localparam int F1Span = 300;
  localparam int F2Num  = 148;
  localparam int F2Den  = 100;
  // ceil(2^24 / 100): exact floor for f1 * 148 over the whole tuning range
  localparam int Recip100 = ((1 << 24) + F2Den - 1) / F2Den;
  localparam int F2Mul    = F2Num * Recip100;
  localparam int StepHz   = 97392;
  localparam int SvfHz    = 2390;
  localparam int DampQ24  = (2 * (1 << 24)) / 5;

  localparam logic signed [31:0] DriveHalf = 32'sd8388608;

  typedef enum logic [0:0] {
    CFG_TUNING    = 1'b0,
    CFG_ENV_COEFF = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_F1,
    MUL_F2,
    MUL_STEP1,
    MUL_STEP2,
    MUL_COEF,
    MUL_BL,
    MUL_DAMP,
    MUL_HIGH,
    MUL_ENV,
    MUL_DECAY,
    MUL_VEL
  } mul_sel_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_TRIG,
    WB_PHASE,
    WB_F1,
    WB_F2,
    WB_STEP1,
    WB_STEP2,
    WB_COEF,
    WB_BL,
    WB_HIGH,
    WB_BP,
    WB_O,
    WB_ENV,
    WB_OUT
  } wb_sel_e;

  typedef struct packed {
    mul_sel_e mul;
    wb_sel_e  wb;
  } ctrl_t;

  typedef struct packed {
    logic retune;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ src/cdv_ctrl.sv @@
`default_nettype none

module cdv_ctrl import cdv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_cmd_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o
);

  typedef enum logic [3:0] {
    S_DF1,
    S_DF1W,
    S_DF2,
    S_DF2W,
    S_DS1W,
    S_DS2W,
    S_DCW,
    S_IDLE,
    S_BL,
    S_HIGH,
    S_M3,
    S_BP,
    S_M4,
    S_M6,
    S_M5,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   deriving;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    deriving   = 1'b0;
    ctrl_o.mul = MUL_NONE;
    ctrl_o.wb  = WB_NONE;
    unique case (state_q)
      S_DF1: begin
        deriving   = 1'b1;
        ctrl_o.mul = MUL_F1;
        state_d    = S_DF1W;
      end
      S_DF1W: begin
        deriving  = 1'b1;
        ctrl_o.wb = WB_F1;
        state_d   = S_DF2;
      end
      S_DF2: begin
        deriving   = 1'b1;
        ctrl_o.mul = MUL_F2;
        state_d    = S_DF2W;
      end
      S_DF2W: begin
        deriving   = 1'b1;
        ctrl_o.wb  = WB_F2;
        ctrl_o.mul = MUL_STEP1;
        state_d    = S_DS1W;
      end
      S_DS1W: begin
        deriving   = 1'b1;
        ctrl_o.wb  = WB_STEP1;
        ctrl_o.mul = MUL_STEP2;
        state_d    = S_DS2W;
      end
      S_DS2W: begin
        deriving   = 1'b1;
        ctrl_o.wb  = WB_STEP2;
        ctrl_o.mul = MUL_COEF;
        state_d    = S_DCW;
      end
      S_DCW: begin
        deriving  = 1'b1;
        ctrl_o.wb = WB_COEF;
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = !status_i.retune && !pend_q;
        if (status_i.retune || pend_q) begin
          state_d = S_DF1;
        end else if (in_valid_i) begin
          if (in_cmd_i) begin
            ctrl_o.wb = WB_TRIG;
          end else begin
            ctrl_o.wb  = WB_PHASE;
            ctrl_o.mul = MUL_BL;
            state_d    = S_BL;
          end
        end
      end
      S_BL: begin
        ctrl_o.wb  = WB_BL;
        ctrl_o.mul = MUL_DAMP;
        state_d    = S_HIGH;
      end
      S_HIGH: begin
        ctrl_o.wb = WB_HIGH;
        state_d   = S_M3;
      end
      S_M3: begin
        ctrl_o.mul = MUL_HIGH;
        state_d    = S_BP;
      end
      S_BP: begin
        ctrl_o.wb = WB_BP;
        state_d   = S_M4;
      end
      S_M4: begin
        ctrl_o.mul = MUL_ENV;
        state_d    = S_M6;
      end
      S_M6: begin
        ctrl_o.wb  = WB_O;
        ctrl_o.mul = MUL_DECAY;
        state_d    = S_M5;
      end
      S_M5: begin
        ctrl_o.wb  = WB_ENV;
        ctrl_o.mul = MUL_VEL;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          ctrl_o.wb = WB_OUT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_DF1;
      end
    endcase

    if (deriving && status_i.retune) begin
      state_d = S_DF1;
    end
  end

  // tuning written mid-sample: rerun the derivation once back at idle
  always_comb begin
    pend_d = pend_q;
    if (state_d == S_DF1) begin
      pend_d = 1'b0;
    end else if (status_i.retune) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_DF1;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

@@ src/cdv_datapath.sv @@
`default_nettype none

module cdv_datapath import cdv_pkg::*; #(
  parameter int PHASE_BITS = PhaseBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output status_t            status_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [VelW-1:0]    velocity_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [SampleW-1:0] out_sample_o
);

  logic [24:0] tuning_q, env_coeff_q;
  logic [24:0] tuning_clamp, coeff_clamp, vel_clamp;

  logic [9:0]  f1_q, mean_q;
  logic [10:0] f2_q;
  logic [10:0] mean_sum;
  logic [20:0] coef_q;
  logic [PHASE_BITS-1:0] step1_q, step2_q;

  logic [PHASE_BITS-1:0] phase1_q, phase2_q, ph1_sum, ph2_sum;
  logic signed [31:0] drive_q, drive_d;
  logic [31:0] bl_q, bp_q, high_q, o_q, p_q;
  logic [24:0] env_q, vel_q;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic        shifted;
  logic [31:0] prod_sel;

  logic signed [21:0] scaled;
  logic [SampleW-1:0] sat;

  logic               out_valid_q;
  logic [SampleW-1:0] out_data_q;

  assign tuning_clamp = (tuning_q > OneQ24) ? OneQ24 : tuning_q;
  assign coeff_clamp  = (env_coeff_q > OneQ24) ? OneQ24 : env_coeff_q;
  assign vel_clamp    = (velocity_i > OneQ24) ? OneQ24 : velocity_i;

  assign status_o.retune   = cfg_we_i && (cfg_idx_i == CFG_TUNING);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // shared multiplier
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    shifted = 1'b1;
    unique case (ctrl_i.mul)
      MUL_F1: begin
        op_a = 32'(F1Span);
        op_b = {7'b0, tuning_clamp};
      end
      MUL_F2: begin
        op_a = {22'b0, f1_q};
        op_b = 32'(F2Mul);
      end
      MUL_STEP1: begin
        op_a    = {22'b0, f1_q};
        op_b    = 32'(StepHz);
        shifted = 1'b0;
      end
      MUL_STEP2: begin
        op_a    = {21'b0, f2_q};
        op_b    = 32'(StepHz);
        shifted = 1'b0;
      end
      MUL_COEF: begin
        op_a    = {22'b0, mean_q};
        op_b    = 32'(SvfHz);
        shifted = 1'b0;
      end
      MUL_BL: begin
        op_a = {11'b0, coef_q};
        op_b = bp_q;
      end
      MUL_DAMP: begin
        op_a = 32'(DampQ24);
        op_b = bp_q;
      end
      MUL_HIGH: begin
        op_a = {11'b0, coef_q};
        op_b = high_q;
      end
      MUL_ENV: begin
        op_a = bp_q;
        op_b = {7'b0, env_q};
      end
      MUL_DECAY: begin
        op_a = {7'b0, env_q};
        op_b = {7'b0, coeff_clamp};
      end
      MUL_VEL: begin
        op_a = o_q;
        op_b = {7'b0, vel_q};
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_sel = shifted ? prod[55:24] : prod[31:0];

  assign ph1_sum  = phase1_q + step1_q;
  assign ph2_sum  = phase2_q + step2_q;
  assign mean_sum = {1'b0, f1_q} + f2_q;

  always_comb begin
    if (ph1_sum[PHASE_BITS-1] != ph2_sum[PHASE_BITS-1]) begin
      drive_d = '0;
    end else if (ph1_sum[PHASE_BITS-1]) begin
      drive_d = -DriveHalf;
    end else begin
      drive_d = DriveHalf;
    end
  end

  assign scaled = p_q[31:10];
  always_comb begin
    if (scaled > 22'sd32767) begin
      sat = 16'h7fff;
    end else if (scaled < -22'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = scaled[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q    <= TuningRst;
      env_coeff_q <= EnvCoeffRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TUNING) begin
        tuning_q <= cfg_wdata_i;
      end else begin
        env_coeff_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase1_q    <= '0;
      phase2_q    <= '0;
      bl_q        <= '0;
      bp_q        <= '0;
      env_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wb == WB_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (ctrl_i.wb)
        WB_TRIG: begin
          vel_q <= vel_clamp;
          env_q <= OneQ24;
        end
        WB_PHASE: begin
          phase1_q <= ph1_sum;
          phase2_q <= ph2_sum;
        end
        WB_BL:   bl_q  <= bl_q + p_q;
        WB_BP:   bp_q  <= bp_q + p_q;
        WB_ENV:  env_q <= p_q[24:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul != MUL_NONE) begin
      p_q <= prod_sel;
    end
    unique case (ctrl_i.wb)
      WB_F1:    f1_q   <= 10'(F1Base) + {1'b0, p_q[8:0]};
      WB_F2:    f2_q   <= p_q[10:0];
      WB_STEP1: begin
        step1_q <= p_q[31 -: PHASE_BITS];
        mean_q  <= mean_sum[10:1];
      end
      WB_STEP2: step2_q    <= p_q[31 -: PHASE_BITS];
      WB_COEF:  coef_q     <= p_q[20:0];
      WB_PHASE: drive_q    <= drive_d;
      WB_HIGH:  high_q     <= drive_q - bl_q - p_q;
      WB_O:     o_q        <= p_q;
      WB_OUT:   out_data_q <= sat;
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_data_q;

endmodule

`default_nettype wire

@@ src/cowbell_drum_voice.sv @@
// Cowbell drum voice: two detuned square oscillators through a bandpass,
// shaped by a decaying envelope and the note velocity.
// Input stream (s_axis): tuser is the command, 0 = tick, 1 = trigger;
// tdata carries the Q24 velocity, used only by a trigger.
// Output stream (m_axis): one signed 16-bit sample per tick, none per trigger.
// Config port: cfg_we_i writes register cfg_idx_i (0 tuning, 1 envelope decay).
// A trigger transfer leaves the voice idle; triggers can come every cycle while no
// tuning write or derivation holds tready low. A tick runs eight steps after its
// transfer, using one shared 32x32 multiplier; its sample is written to the
// output register in the last step, and only then is the next item taken.
// Reset, and every write of the tuning register, starts a pass that derives
// the oscillator steps and filter coefficient (after a running tick returns
// to idle, if one is running); s_axis_tready_o is low during it.
// The output register holds a sample until it is taken, and the next item can
// already be accepted; a finished tick waits in its last step while the
// output register is still full, holding tready low.
`default_nettype none

module cowbell_drum_voice import cdv_pkg::*; #(
  parameter int PHASE_BITS = PhaseBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,  // [24:0] velocity
  input  logic               s_axis_tuser_i,  // [0] cmd
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [SampleW-1:0] m_axis_tdata_o,  // [15:0] sample
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  ctrl_t   ctrl;
  status_t status;

  cdv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .status_i   (status),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  cdv_datapath #(
    .PHASE_BITS (PHASE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .velocity_i   (s_axis_tdata_i[VelW-1:0]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_sample_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ src/cdv_checker.sv @@
`default_nettype none
`include "cowbell_drum_voice_macros.svh"

module cdv_checker import cdv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               s_axis_tuser_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [SampleW-1:0] m_axis_tdata_o,
  input logic               cfg_we_i,
  input logic [0:0]         cfg_idx_i
);

  logic tick_xfer, trig_xfer, tune_wr, out_stall;

  assign tick_xfer = s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i;
  assign trig_xfer = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i;
  assign tune_wr   = cfg_we_i && (cfg_idx_i == CFG_TUNING);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  `CDV_ASSERT_NEXT(a_out_valid_held, out_stall, m_axis_tvalid_o, "sample dropped while stalled")
  `CDV_ASSERT_NEXT(a_out_data_held, out_stall, $stable(m_axis_tdata_o), "sample changed while stalled")
  `CDV_ASSERT_NEXT(a_tick_busy, tick_xfer, !s_axis_tready_o, "ready right after a tick")
  `CDV_ASSERT_NEXT(a_retune_busy, tune_wr, !s_axis_tready_o, "ready right after a tuning write")
  `CDV_ASSERT_SAME(a_trig_fast, trig_xfer ##1 !tune_wr, s_axis_tready_o, "trigger held the input")

endmodule

bind cowbell_drum_voice cdv_checker u_cdv_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cdv_pkg::*;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_TRIG = 1'b1;

  localparam logic [24:0] ONE_Q24      = 25'h100_0000;
  localparam logic [24:0] VEL_MAX      = 25'h1FF_FFFF;
  localparam logic [24:0] TUNING_RESET = 25'd8388608;
  localparam logic [24:0] DECAY_RESET  = 25'd16775631;

  localparam logic [31:0] HALF_Q24     = 32'h0080_0000;
  localparam logic [31:0] DAMP_Q24     = 32'd6710886;  // 0.4
  localparam logic [31:0] F1_BASE      = 32'd400;
  localparam logic [63:0] F1_SPAN      = 64'd300;
  localparam logic [31:0] F2_RATIO     = 32'd148;
  localparam logic [31:0] PERCENT      = 32'd100;
  localparam logic [31:0] PHASE_INC_HZ = 32'd97392;
  localparam logic [31:0] SVF_PER_HZ   = 32'd2390;

  localparam int NUM_PHASES    = 8;
  localparam int PHASE_NOTES   = 144;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic        cmd;
    logic [24:0] velocity;
  } note_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               s_valid   = 1'b0;
  logic               s_ready;
  logic [31:0]        s_tdata   = '0;
  logic               s_tuser   = 1'b0;
  logic               m_valid;
  logic               m_ready   = 1'b0;
  logic [SampleW-1:0] m_tdata;
  logic               cfg_we    = 1'b0;
  cfg_idx_e           cfg_idx   = CFG_TUNING;
  logic [CfgW-1:0]    cfg_wdata = '0;

  note_t              note_q[$];
  note_t              next_note;
  logic [SampleW-1:0] expected_samples[$];
  logic [SampleW-1:0] exp_sample;
  logic               in_fire        = 1'b0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 error_count    = 0;
  int                 stall_cycles   = 0;

  // voice state
  logic [24:0] tuning_reg = TUNING_RESET;
  logic [24:0] decay_reg  = DECAY_RESET;
  logic [31:0] osc1_phase = '0;
  logic [31:0] osc2_phase = '0;
  logic [31:0] svf_low    = '0;
  logic [31:0] svf_band   = '0;
  logic [24:0] env_level  = '0;
  logic [24:0] note_vel   = '0;

  cowbell_drum_voice i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] q24_mul(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] prod;
    prod = $signed(a) * $signed(b);
    return prod[55:24];
  endfunction

  function automatic logic [24:0] clamp_q24(input logic [24:0] v);
    return (v > ONE_Q24) ? ONE_Q24 : v;
  endfunction

  task automatic advance_voice(input logic cmd, input logic [24:0] vel_in);
    logic [63:0]        span;
    logic [31:0]        f1, f2, coef, drive, high, outv, env_next;
    logic signed [31:0] scaled;
    if (cmd == CMD_TRIG) begin
      note_vel  = clamp_q24(vel_in);
      env_level = ONE_Q24;
    end else begin
      span = F1_SPAN * 64'(clamp_q24(tuning_reg));
      f1   = F1_BASE + span[55:24];
      f2   = (f1 * F2_RATIO) / PERCENT;
      coef = ((f1 + f2) / 32'd2) * SVF_PER_HZ;
      osc1_phase = osc1_phase + f1 * PHASE_INC_HZ;
      osc2_phase = osc2_phase + f2 * PHASE_INC_HZ;
      if (osc1_phase[31] != osc2_phase[31]) begin
        drive = '0;
      end else if (osc1_phase[31]) begin
        drive = -HALF_Q24;
      end else begin
        drive = HALF_Q24;
      end
      svf_low  = svf_low + q24_mul(coef, svf_band);
      high     = drive - svf_low - q24_mul(DAMP_Q24, svf_band);
      svf_band = svf_band + q24_mul(coef, high);
      outv = q24_mul(svf_band, {7'd0, env_level});
      outv = q24_mul(outv, {7'd0, note_vel});
      env_next  = q24_mul({7'd0, env_level}, {7'd0, clamp_q24(decay_reg)});
      env_level = env_next[24:0];
      scaled = $signed(outv) >>> 10;
      if (scaled > 32'sd32767) begin
        scaled = 32'sd32767;
      end else if (scaled < -32'sd32768) begin
        scaled = -32'sd32768;
      end
      expected_samples.push_back(scaled[15:0]);
    end
  endtask

  function automatic void push_note(input logic cmd, input logic [24:0] vel);
    note_t n;
    n.cmd      = cmd;
    n.velocity = vel;
    note_q.push_back(n);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TUNING) begin
      tuning_reg = value;
    end else begin
      decay_reg = value;
    end
  endtask

  // wait for the voice to go idle; triggers leave no sample behind
  task automatic settle();
    while (note_q.size() != 0 || s_valid || expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!s_valid || in_fire) begin
      if (note_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_note = note_q.pop_front();
        s_valid <= 1'b1;
        s_tuser <= next_note.cmd;
        s_tdata <= {7'd0, next_note.velocity};
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample: expected none, actual %0d", $signed(m_tdata));
          error_count++;
        end else begin
          exp_sample = expected_samples.pop_front();
          if (m_tdata !== exp_sample) begin
            $error("sample mismatch: expected %0d, actual %0d",
                   $signed(exp_sample), $signed(m_tdata));
            error_count++;
          end
        end
      end
      if (s_valid && s_ready) begin
        advance_voice(s_tuser, s_tdata[24:0]);
      end
      if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
    in_fire <= s_valid && s_ready;
  end

  initial begin
    logic [24:0] tune_val;
    logic [24:0] decay_val;
    logic [24:0] vel;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed notes at reset settings
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    push_note(CMD_TICK, 25'd0);          // no note yet: silent
    push_note(CMD_TICK, VEL_MAX);        // velocity on tick is ignored
    push_note(CMD_TRIG, 25'd0);
    push_note(CMD_TICK, 25'h0AA_AAAA);
    push_note(CMD_TICK, 25'h155_5555);
    push_note(CMD_TRIG, VEL_MAX);        // clamped to one
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TRIG, ONE_Q24);
    push_note(CMD_TRIG, 25'h0AA_AAAA);   // back to back, last one wins
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TRIG, 25'h155_5555);   // above one
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TICK, 25'd0);
    push_note(CMD_TRIG, 25'h0FF_FFFF);
    push_note(CMD_TICK, VEL_MAX);
    push_note(CMD_TICK, 25'd0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          tune_val  = '0;
          decay_val = '0;
        end
        1: begin
          tune_val  = ONE_Q24;
          decay_val = ONE_Q24;
        end
        2: begin
          tune_val  = VEL_MAX;
          decay_val = VEL_MAX;
        end
        3: begin
          tune_val  = 25'($urandom_range(ONE_Q24));
          decay_val = ONE_Q24 - 25'($urandom_range(4000));
        end
        5: begin
          tune_val  = TUNING_RESET;
          decay_val = DECAY_RESET;
        end
        6: begin
          tune_val  = 25'($urandom_range(ONE_Q24));
          decay_val = ONE_Q24 - 25'($urandom_range(200000));
        end
        default: begin
          tune_val  = 25'($urandom);
          decay_val = 25'($urandom);
        end
      endcase
      write_reg(CFG_TUNING, tune_val);
      write_reg(CFG_ENV_COEFF, decay_val);

      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
      endcase

      push_note(CMD_TRIG, ONE_Q24);
      for (int n = 1; n < PHASE_NOTES; n++) begin
        if ($urandom_range(11) == 0) begin
          case ($urandom_range(3))
            0:       vel = ONE_Q24;
            1:       vel = VEL_MAX;
            2:       vel = 25'($urandom_range(ONE_Q24));
            default: vel = 25'($urandom);
          endcase
          push_note(CMD_TRIG, vel);
        end else begin
          push_note(CMD_TICK, 25'($urandom));
        end
      end
      settle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/cdv_pkg.sv
src/cdv_ctrl.sv
src/cdv_datapath.sv
src/cowbell_drum_voice.sv
src/cdv_checker.sv
tb/testbench.sv
